// ----- design/shell_command_lexer_defines.svh -----
// Assertion macros for the shell command lexer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SHELL_COMMAND_LEXER_DEFINES_SVH
`define SHELL_COMMAND_LEXER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCL_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/scl_pkg.sv -----
// Shared types for the shell command lexer: result word layout and codes.
// No dependencies.
package scl_pkg;

    localparam int MAX_RES = 4;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        CLS_NONE  = 4'd0,
        CLS_STR   = 4'd1,
        CLS_STREX = 4'd2,
        CLS_PIPE  = 4'd3,
        CLS_EACH  = 4'd4,
        CLS_SEMI  = 4'd5,
        CLS_LB    = 4'd6,
        CLS_RB    = 4'd7,
        CLS_LCB   = 4'd8,
        CLS_RCB   = 4'd9,
        CLS_NUM   = 4'd10,
        CLS_OPT   = 4'd11,
        CLS_VAR   = 4'd12,
        CLS_WORD  = 4'd13
    } class_t;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_COMMENT = 2'd2
    } lex_mode_t;

    typedef struct packed {
        kind_t       kind;
        class_t      cls;
        logic [7:0]  text;
        logic [15:0] line;
        logic        last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [CNT_W-1:0]   count;
    } res_list_t;

endpackage

// ----- design/scl_core.sv -----
// Lexer state and per-character step logic for the shell command lexer.
// Depends on scl_pkg; produces the full result list of one input word.
module scl_core
    import scl_pkg::*;
#(
    parameter int LINE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] char_byte,
    input  logic       has_byte,
    input  logic       end_of_input,
    output res_list_t  res_list
);

    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    typedef struct packed {
        logic                 held_valid;
        logic                 held_dash;
        class_t               cls;
        logic                 has_text;
        logic [LINE_BITS-1:0] start_line;
        logic [LINE_BITS-1:0] line_count;
        lex_mode_t            mode;
        logic                 quote_single;
        logic                 esc_pending;
    } lex_state_t;

    typedef struct packed {
        lex_state_t st;
        res_list_t  rl;
    } work_t;

    localparam lex_state_t STATE_RESET = '{
        held_valid:   1'b0,
        held_dash:    1'b0,
        cls:          CLS_NONE,
        has_text:     1'b0,
        start_line:   LINE_ONE,
        line_count:   LINE_ONE,
        mode:         MODE_NORMAL,
        quote_single: 1'b0,
        esc_pending:  1'b0
    };

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_numch(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c == CH_DOT);
    endfunction

    function automatic class_t punct_class(logic [7:0] c);
        class_t r;
        unique case (c)
            CH_PIPE:   r = CLS_PIPE;
            CH_AMP:    r = CLS_EACH;
            CH_SEMI:   r = CLS_SEMI;
            CH_LBRACK: r = CLS_LB;
            CH_RBRACK: r = CLS_RB;
            CH_LBRACE: r = CLS_LCB;
            CH_RBRACE: r = CLS_RCB;
            default:   r = CLS_NONE;
        endcase
        return r;
    endfunction

    // Append one result word carrying the current class and start line.
    function automatic work_t put_res(work_t w, kind_t k, logic [7:0] b);
        work_t r;
        r = w;
        r.rl.res[w.rl.count[IDX_W-1:0]] = '{
            kind: k,
            cls:  w.st.cls,
            text: b,
            line: 16'(w.st.start_line),
            last: 1'b0
        };
        r.rl.count = w.rl.count + CNT_W'(1);
        return r;
    endfunction

    function automatic work_t emit_text(work_t w, logic [7:0] b);
        work_t r;
        r = put_res(w, KIND_TEXT, b);
        r.st.has_text = 1'b1;
        return r;
    endfunction

    function automatic work_t end_token(work_t w);
        work_t r;
        r = put_res(w, KIND_END, 8'h00);
        r.st.start_line = r.st.line_count;
        r.st.cls        = CLS_NONE;
        r.st.has_text   = 1'b0;
        return r;
    endfunction

    function automatic work_t punct(work_t w, class_t p);
        work_t r;
        r = w;
        if (r.st.has_text)
        begin
            r = end_token(r);
        end
        r.st.cls = p;
        r = end_token(r);
        return r;
    endfunction

    lex_state_t           state_reg;
    lex_state_t           state_next;
    work_t                w;
    logic                 consumed;
    class_t               pc;
    logic [7:0]           esc_char;
    logic [IDX_W-1:0]     lidx;

    always_comb
    begin
        w        = '{st: state_reg, rl: '0};
        consumed = 1'b0;
        pc       = punct_class(char_byte);
        esc_char = char_byte;
        lidx     = '0;

        if (has_byte)
        begin
            // resolve the held '-' or '/' with this character as lookahead
            if (w.st.held_valid)
            begin
                w.st.held_valid = 1'b0;
                if (w.st.held_dash)
                begin
                    if (is_numch(char_byte))
                    begin
                        w.st.cls = CLS_NUM;
                        w = emit_text(w, CH_DASH);
                    end
                    else
                    begin
                        w.st.cls = CLS_OPT;
                    end
                end
                else if (char_byte == CH_SLASH)
                begin
                    w.st.mode = MODE_COMMENT;
                    consumed  = 1'b1;
                end
                else
                begin
                    w = emit_text(w, CH_SLASH);
                end
            end

            if (!consumed)
            begin
                if (char_byte == CH_NL && w.st.line_count != LINE_TOP)
                begin
                    w.st.line_count = w.st.line_count + LINE_ONE;
                end
                case (w.st.mode)
                    MODE_COMMENT:
                    begin
                        if (char_byte == CH_NL)
                        begin
                            w.st.mode = MODE_NORMAL;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (w.st.esc_pending)
                        begin
                            w.st.esc_pending = 1'b0;
                            if (char_byte == CH_LOWER_N)
                            begin
                                esc_char = CH_NL;
                            end
                            else if (char_byte == CH_LOWER_T)
                            begin
                                esc_char = CH_TAB;
                            end
                            w = emit_text(w, esc_char);
                        end
                        else if (char_byte == (w.st.quote_single ? CH_SQUOTE : CH_DQUOTE))
                        begin
                            w = end_token(w);
                            w.st.mode = MODE_NORMAL;
                        end
                        else if (char_byte == CH_BSLASH)
                        begin
                            w.st.esc_pending = 1'b1;
                        end
                        else
                        begin
                            w = emit_text(w, char_byte);
                        end
                    end
                    default:
                    begin
                        if (pc != CLS_NONE)
                        begin
                            w = punct(w, pc);
                        end
                        else if (char_byte == CH_SQUOTE || char_byte == CH_DQUOTE)
                        begin
                            if (w.st.has_text)
                            begin
                                w = end_token(w);
                            end
                            w.st.quote_single = (char_byte == CH_SQUOTE);
                            w.st.cls          = w.st.quote_single ? CLS_STR : CLS_STREX;
                            w.st.mode         = MODE_STRING;
                            w.st.esc_pending  = 1'b0;
                        end
                        else if (is_space(char_byte))
                        begin
                            if (w.st.has_text)
                            begin
                                w = end_token(w);
                            end
                        end
                        else if ((w.st.cls == CLS_NONE || w.st.cls == CLS_NUM)
                                 && is_numch(char_byte))
                        begin
                            w.st.cls = CLS_NUM;
                            w = emit_text(w, char_byte);
                        end
                        else if (w.st.cls == CLS_NONE && char_byte == CH_DASH)
                        begin
                            w.st.held_valid = 1'b1;
                            w.st.held_dash  = 1'b1;
                        end
                        else if (w.st.cls == CLS_NONE && char_byte == CH_DOLLAR)
                        begin
                            w.st.cls = CLS_VAR;
                        end
                        else if (char_byte == CH_SLASH)
                        begin
                            w.st.held_valid = 1'b1;
                            w.st.held_dash  = 1'b0;
                        end
                        else
                        begin
                            if (w.st.cls == CLS_NONE)
                            begin
                                w.st.cls = CLS_WORD;
                            end
                            w = emit_text(w, char_byte);
                        end
                    end
                endcase
            end
        end

        state_next = w.st;

        if (end_of_input)
        begin
            // flush: resolve a held char without lookahead, then close out
            if (w.st.held_valid)
            begin
                w.st.held_valid = 1'b0;
                if (w.st.held_dash)
                begin
                    w.st.cls = CLS_OPT;
                end
                else
                begin
                    w = emit_text(w, CH_SLASH);
                end
            end
            if (w.st.mode == MODE_STRING)
            begin
                w = put_res(w, KIND_ERROR, 8'h00);
            end
            else if (w.st.has_text)
            begin
                w = end_token(w);
            end
            if (w.rl.count != '0)
            begin
                lidx = IDX_W'(w.rl.count - CNT_W'(1));
                w.rl.res[lidx].last = 1'b1;
            end
            state_next = STATE_RESET;
        end
    end

    assign res_list = w.rl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/scl_outq.sv -----
// Result register of the shell command lexer: holds one input word's results
// and hands them out one per cycle while out_ready is high. Depends on scl_pkg.
module scl_outq
    import scl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_list_t   list_in,
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [3:0]  token_class,
    output logic [7:0]  text_byte,
    output logic [15:0] token_line,
    output logic        last_result
);

    res_t [MAX_RES-1:0] res_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               pop;
    logic               last_pop;
    res_t               cur;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign last_pop  = pop && (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));
    assign free      = !out_valid || last_pop;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = list_in.count;
            idx_next = '0;
        end
        else if (last_pop)
        begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= list_in.res;
        end
    end

    assign cur         = res_reg[idx_reg];
    assign result_kind = cur.kind;
    assign token_class = cur.cls;
    assign text_byte   = cur.text;
    assign token_line  = cur.line;
    assign last_result = cur.last;

endmodule

// ----- design/shell_command_lexer.sv -----
// Shell command lexer: takes one character per input word and streams out
// token text bytes, token ends and unclosed-string errors.
//
// Input channel (in_valid/in_ready): char_byte, has_byte, end_of_input.
// Output channel (out_valid/out_ready): result_kind, token_class, text_byte,
// token_line, last_result. One input word yields zero to three result words.
//
// A word accepted into the input register is lexed when the output register
// is free, which loads its results into the output register. Throughput is set
// by the output register, which delivers one result word per cycle while
// out_ready is high: a new input word enters every cycle as long as each yields
// at most one result, a word with more results holds the lexer until its last
// result is taken, and a word with no result leaves the output register free.
// A word with end_of_input flushes the pending token, marks its last result,
// and returns the lexer to its reset state (line 1, normal mode).
// Reset clears the lexer state and drops any queued results.
// When out_ready is low the results hold, the input register fills, and
// in_ready drops until the output register drains.
`include "shell_command_lexer_defines.svh"

module shell_command_lexer
    import scl_pkg::*;
#(
    parameter int LINE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        has_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [3:0]  token_class,
    output logic [7:0]  text_byte,
    output logic [15:0] token_line,
    output logic        last_result
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       has_byte_reg;
    logic       eoi_reg;
    logic       fire;
    logic       q_free;
    res_list_t  list_next;
    logic       end_word;
    logic       err_word;
    logic       str_cls;
    logic       flush_res;

    assign fire     = in_valid_reg && q_free;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg     <= char_byte;
            has_byte_reg <= has_byte;
            eoi_reg      <= end_of_input;
        end
    end

    scl_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (fire),
        .char_byte    (char_reg),
        .has_byte     (has_byte_reg),
        .end_of_input (eoi_reg),
        .res_list     (list_next)
    );

    scl_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .list_in     (list_next),
        .free        (q_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .token_class (token_class),
        .text_byte   (text_byte),
        .token_line  (token_line),
        .last_result (last_result)
    );

    assign end_word  = out_valid && (result_kind == KIND_END);
    assign err_word  = out_valid && (result_kind == KIND_ERROR);
    assign str_cls   = (token_class == CLS_STR) || (token_class == CLS_STREX);
    assign flush_res = fire && eoi_reg && (list_next.count != '0);

    `SCL_ASSERT(a_end_no_text, end_word, text_byte == 8'h00, "token end word carries text")
    `SCL_ASSERT(a_error_last, err_word, last_result, "string error word is not last")
    `SCL_ASSERT(a_error_class, err_word, str_cls, "string error word has a non-string class")
    `SCL_ASSERT_NEXT(a_flush_out, flush_res, out_valid, "flush results not offered")

endmodule
